@@ sv/crc_frame_receiver_assert.svh @@
// Assertion macros for the frame receiver checker.
// Included by crc_frame_receiver_chk.sv; expects clk and rst in scope.
`ifndef CRC_FRAME_RECEIVER_ASSERT_SVH
`define CRC_FRAME_RECEIVER_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define CFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CFR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/cfr_pkg.sv @@
// Shared types, codes and the CRC16 byte update for the frame receiver.
// No dependencies; used by the parser, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TIMEOUT      = 3'd1,
    ST_CRC_ERR      = 3'd2,
    ST_CMD_MISMATCH = 3'd3,
    ST_REMOTE_ERR   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_SYNC_FIRST       = 3'd0,
    REG_SYNC_SECOND      = 3'd1,
    REG_EXPECTED_COMMAND = 3'd2,
    REG_ERROR_FLAG_MASK  = 3'd3,
    REG_PAYLOAD_CAPACITY = 3'd4,
    REG_TIMEOUT_TICKS    = 3'd5
  } cfg_reg_t;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [7:0]  RST_SYNC_FIRST       = 8'hAA;
  localparam logic [7:0]  RST_SYNC_SECOND      = 8'h55;
  localparam logic [7:0]  RST_EXPECTED_COMMAND = 8'h00;
  localparam logic [7:0]  RST_ERROR_FLAG_MASK  = 8'h01;
  localparam logic [10:0] RST_PAYLOAD_CAPACITY = 11'd1024;
  localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd200;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  expected_command;
    logic [7:0]  error_flag_mask;
    logic [10:0] payload_capacity;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  payload_index;
    logic [7:0]  payload_value;
    logic [7:0]  reply_command;
    logic [7:0]  reply_flags;
    logic [10:0] reply_length;
    status_t     status;
  } result_t;

  // Reflected CRC16-CCITT, one byte fed LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/cfr_parser.sv @@
// Frame parser: sync hunt, header, payload, CRC check and timeout timer.
// Depends on cfr_pkg; produces at most one result per accepted item.
`timescale 1ns / 1ps
`default_nettype none

module cfr_parser #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [1:0]       opcode,
  input  wire logic [7:0]       rx_byte,
  input  wire cfr_pkg::cfg_t    cfg,
  output logic                  res_valid,
  output cfr_pkg::result_t      res
);
  import cfr_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W = (LEN_W > 11) ? LEN_W : 11;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SYNC1, PH_SYNC2, PH_CMD, PH_FLAGS,
    PH_LEN0, PH_LEN1, PH_PAY, PH_CRC0, PH_CRC1
  } phase_t;

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  length_seen, length_seen_next;
  logic [LEN_W-1:0]  byte_count, byte_count_next;
  logic [LEN_W-1:0]  count_inc;
  logic [7:0]        len_low, len_low_next;
  logic [15:0]       running_crc, running_crc_next;
  logic [15:0]       crc_fed;
  logic [15:0]       full_length;
  logic [15:0]       elapsed, elapsed_next, elapsed_inc;
  logic [7:0]        crc_low_byte, crc_low_byte_next;
  logic [7:0]        command_seen, command_seen_next;
  logic [7:0]        flags_seen, flags_seen_next;

  assign crc_fed     = crc_feed(running_crc, rx_byte);
  assign full_length = {rx_byte, len_low};
  assign count_inc   = byte_count + 1'b1;
  assign elapsed_inc = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;

  always_comb begin
    phase_next        = phase;
    length_seen_next  = length_seen;
    byte_count_next   = byte_count;
    len_low_next      = len_low;
    running_crc_next  = running_crc;
    elapsed_next      = elapsed;
    crc_low_byte_next = crc_low_byte;
    command_seen_next = command_seen;
    flags_seen_next   = flags_seen;
    res_valid         = 1'b0;
    res               = '0;
    if (accept) begin
      unique case (opcode_t'(opcode))
        OP_START: begin
          phase_next        = PH_SYNC1;
          running_crc_next  = CRC_SEED;
          byte_count_next   = '0;
          elapsed_next      = '0;
          length_seen_next  = '0;
          len_low_next      = '0;
          crc_low_byte_next = '0;
          command_seen_next = '0;
          flags_seen_next   = '0;
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= cfg.timeout_ticks) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = 1'b1;
              res.status = ST_TIMEOUT;
            end
          end
        end
        OP_BYTE: begin
          unique case (phase)
            PH_IDLE: begin
            end
            PH_SYNC1: begin
              if (rx_byte == cfg.sync_first) begin
                phase_next = PH_SYNC2;
              end
            end
            PH_SYNC2: begin
              if (rx_byte == cfg.sync_second) begin
                phase_next = PH_CMD;
              end else if (rx_byte == cfg.sync_first) begin
                phase_next = PH_SYNC2;
              end else begin
                phase_next = PH_SYNC1;
              end
              running_crc_next = CRC_SEED;
            end
            PH_CMD: begin
              command_seen_next = rx_byte;
              running_crc_next  = crc_fed;
              phase_next        = PH_FLAGS;
            end
            PH_FLAGS: begin
              flags_seen_next  = rx_byte;
              running_crc_next = crc_fed;
              phase_next       = PH_LEN0;
            end
            PH_LEN0: begin
              len_low_next     = rx_byte;
              running_crc_next = crc_fed;
              phase_next       = PH_LEN1;
            end
            PH_LEN1: begin
              running_crc_next = crc_fed;
              byte_count_next  = '0;
              if (full_length > 16'(MAX_PAYLOAD)) begin
                phase_next       = PH_SYNC1;
                running_crc_next = CRC_SEED;
              end else begin
                length_seen_next = full_length[LEN_W-1:0];
                phase_next       = (full_length == 16'd0) ? PH_CRC0 : PH_PAY;
              end
            end
            PH_PAY: begin
              running_crc_next = crc_fed;
              if (CMP_W'(byte_count) < CMP_W'(cfg.payload_capacity)) begin
                res_valid         = 1'b1;
                res.kind          = 1'b0;
                res.payload_index = 10'(byte_count);
                res.payload_value = rx_byte;
                res.reply_command = command_seen;
                res.reply_flags   = flags_seen;
                res.reply_length  = 11'(length_seen);
                res.status        = ST_OK;
              end
              byte_count_next = count_inc;
              if (count_inc >= length_seen) begin
                phase_next = PH_CRC0;
              end
            end
            PH_CRC0: begin
              crc_low_byte_next = rx_byte;
              phase_next        = PH_CRC1;
            end
            PH_CRC1: begin
              phase_next        = PH_IDLE;
              res_valid         = 1'b1;
              res.kind          = 1'b1;
              res.reply_command = command_seen;
              res.reply_flags   = flags_seen;
              res.reply_length  = 11'(length_seen);
              if ({rx_byte, crc_low_byte} != running_crc) begin
                res.status = ST_CRC_ERR;
              end else if (command_seen != cfg.expected_command) begin
                res.status = ST_CMD_MISMATCH;
              end else if ((flags_seen & cfg.error_flag_mask) != 8'd0) begin
                res.status = ST_REMOTE_ERR;
              end else begin
                res.status = ST_OK;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      length_seen  <= '0;
      byte_count   <= '0;
      len_low      <= '0;
      running_crc  <= CRC_SEED;
      elapsed      <= '0;
      crc_low_byte <= '0;
      command_seen <= '0;
      flags_seen   <= '0;
    end else begin
      phase        <= phase_next;
      length_seen  <= length_seen_next;
      byte_count   <= byte_count_next;
      len_low      <= len_low_next;
      running_crc  <= running_crc_next;
      elapsed      <= elapsed_next;
      crc_low_byte <= crc_low_byte_next;
      command_seen <= command_seen_next;
      flags_seen   <= flags_seen_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/crc_frame_receiver.sv @@
// Top level of the frame receiver: configuration registers, parser and output buffer.
// Depends on cfr_pkg and cfr_parser.
`timescale 1ns / 1ps
`default_nettype none

// The receiver takes one item per clock cycle while in_stall is low. The result an
// item causes is registered in the output register, or in the second buffer entry
// while out_stall holds the output. The bytewise CRC16 update and the frame state
// machine both finish between the parser state registers and the output register. A
// two-entry output buffer lets one more item in while a result is held by out_stall;
// in_stall rises only when both entries are full. Registers must be written only
// while no frame result is outstanding.
module crc_frame_receiver #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    opcode,
  input  wire logic [7:0]                    rx_byte,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               result_kind,
  output logic [9:0]                         payload_index,
  output logic [7:0]                         payload_value,
  output logic [7:0]                         reply_command,
  output logic [7:0]                         reply_flags,
  output logic [10:0]                        reply_length,
  output logic [2:0]                         status
);
  import cfr_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first       <= RST_SYNC_FIRST;
      cfg.sync_second      <= RST_SYNC_SECOND;
      cfg.expected_command <= RST_EXPECTED_COMMAND;
      cfg.error_flag_mask  <= RST_ERROR_FLAG_MASK;
      cfg.payload_capacity <= RST_PAYLOAD_CAPACITY;
      cfg.timeout_ticks    <= RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SYNC_FIRST:       cfg.sync_first       <= cfg_data[7:0];
        REG_SYNC_SECOND:      cfg.sync_second      <= cfg_data[7:0];
        REG_EXPECTED_COMMAND: cfg.expected_command <= cfg_data[7:0];
        REG_ERROR_FLAG_MASK:  cfg.error_flag_mask  <= cfg_data[7:0];
        REG_PAYLOAD_CAPACITY: cfg.payload_capacity <= cfg_data[10:0];
        REG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  cfr_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        if (res_valid) begin
          out_res <= res;
        end
      end
    end else if (res_valid) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign in_stall      = skid_valid;
  assign result_kind   = out_res.kind;
  assign payload_index = out_res.payload_index;
  assign payload_value = out_res.payload_value;
  assign reply_command = out_res.reply_command;
  assign reply_flags   = out_res.reply_flags;
  assign reply_length  = out_res.reply_length;
  assign status        = out_res.status;

endmodule

`default_nettype wire

@@ sv/crc_frame_receiver_chk.sv @@
// Port-level checker for the frame receiver, bound to the top level.
// Depends on cfr_pkg and crc_frame_receiver_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "crc_frame_receiver_assert.svh"

module crc_frame_receiver_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        result_kind,
  input wire logic [9:0]  payload_index,
  input wire logic [7:0]  payload_value,
  input wire logic [7:0]  reply_command,
  input wire logic [7:0]  reply_flags,
  input wire logic [10:0] reply_length,
  input wire logic [2:0]  status
);
  import cfr_pkg::*;

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
      $stable(payload_index) && $stable(payload_value) && $stable(status);
  endproperty

  property p_reset_empty;
    rst |=> !out_valid && !in_stall;
  endproperty

  property p_payload_ok;
    out_valid && !result_kind |-> status == ST_OK;
  endproperty

  property p_finish_clean;
    out_valid && result_kind |->
      payload_index == 10'd0 && payload_value == 8'd0 && status <= ST_REMOTE_ERR;
  endproperty

  property p_timeout_clean;
    out_valid && result_kind && status == ST_TIMEOUT |->
      reply_command == 8'd0 && reply_flags == 8'd0 && reply_length == 11'd0;
  endproperty

  `CFR_ASSERT(a_out_hold, p_out_hold, "Stalled result changed")
  `CFR_ASSERT_RST(a_reset_empty, p_reset_empty, "Output buffer not empty after reset")
  `CFR_ASSERT(a_payload_ok, p_payload_ok, "Payload result carries a status")
  `CFR_ASSERT(a_finish_clean, p_finish_clean, "Finish result has payload fields or bad status")
  `CFR_ASSERT(a_timeout_clean, p_timeout_clean, "Timeout result carries header")

endmodule

bind crc_frame_receiver crc_frame_receiver_props u_chk (.*);

`default_nettype wire
